@@ design/prewg_pkg.sv @@
// Shared codes, field widths and status type for the Prewitt gradient block.
// No dependencies; imported by the top level, front end, back end and bench.
package prewg_pkg;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam int FW_BITS     = 12;
  localparam int FH_BITS     = 13;
  localparam int CFG_BITS    = 13;
  localparam int ROW_BITS    = 12;
  localparam int IN_BITS     = 12;
  localparam int MAG_BITS    = 15;
  localparam int MAX_HEIGHT  = 4096;

  localparam logic [FW_BITS-1:0] FW_RESET = 12'd2048;
  localparam logic [FH_BITS-1:0] FH_RESET = 13'd1;

  typedef struct packed {
    logic busy;
    logic draining;
  } front_status_t;

endpackage

@@ design/prewitt_gradient_magnitude.sv @@
// Top level of the Prewitt 3x3 gradient magnitude block.
// Depends on prewg_pkg, prewg_front, prewg_queue and prewg_back.
//
// Usage:
//  - Input channel (in_valid / in_stall): opcode selects a pixel sample or a
//    flush tick. Samples arrive in raster order; the result of a pixel leaves
//    once its lower-right neighbor is in. After the frame's last sample the
//    bottom row is drained by flush ticks, one result each. Flushes outside a
//    drain and samples during a drain are dropped.
//  - Output channel (out_valid / out_stall): magnitude plus frame_last, set on
//    the bottom-right pixel of the frame.
//  - Config port (cfg_write / cfg_index / cfg_data): frame_width, frame_height.
//    Any write restarts the frame; write only while the block is idle.
// Sequencing:
//  - A sample holds the input side for a line-store read, a window update
//    and up to two job pushes; a flush holds it for three column reads
//    through the single line-store port and one job push. Pushes wait on a full queue.
//  - In the back end each result passes a squaring state, SAMPLE_BITS+3 root
//    iterations and an output load; the next job is taken only after the
//    result is loaded, and loading waits while a stalled result is held.
//  - A two-job queue decouples the ends, so the input keeps moving while the
//    output is stalled until the queue fills.
// Reset: counters clear and the frame restarts; line stores are not cleared,
// since every entry a frame reads is written earlier in that frame.
module prewitt_gradient_magnitude import prewg_pkg::*; #(
  parameter int MAX_WIDTH   = 2048,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                opcode,
  input  logic [IN_BITS-1:0]  sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [MAG_BITS-1:0] magnitude,
  output logic                frame_last
);

  localparam int GW = SAMPLE_BITS + 3;
  localparam int JW = 2 * GW + 1;

  front_status_t  fst;
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;
  logic [GW-1:0]  f_gx;
  logic [GW-1:0]  f_gy;
  logic           f_last;
  logic [JW-1:0]  q_out;

  assign in_stall = fst.busy;

  prewg_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .opcode    (opcode),
    .sample    (sample),
    .status    (fst),
    .push      (q_push),
    .push_gx   (f_gx),
    .push_gy   (f_gy),
    .push_last (f_last),
    .full      (q_full)
  );

  prewg_queue #(
    .W (JW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({f_last, f_gy, f_gx}),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  prewg_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_gx       (q_out[GW-1:0]),
    .q_gy       (q_out[2*GW-1:GW]),
    .q_last     (q_out[JW-1]),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .magnitude  (magnitude),
    .frame_last (frame_last)
  );

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full)) else $error("job pushed into a full queue");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && !q_valid)) else $error("job popped from an empty queue");

  a_busy_after_sample: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && opcode == OP_SAMPLE && !fst.draining && !cfg_write)
    |=> in_stall) else $error("sample accepted without line-store update");
`endif

endmodule

@@ design/prewg_queue.sv @@
// Two-entry job queue between the window front end and the root back end.
// Depends on nothing but its width parameter.
module prewg_queue #(
  parameter int W = 31
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] entry [0:1];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign full     = (count == 2'd2);
  assign valid    = (count != 2'd0);
  assign pop_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

endmodule

@@ design/prewg_front.sv @@
// Front end: config registers, raster counters, two line stores, 3x3 window
// and Prewitt gx/gy forming. Pushes jobs to the queue. Uses prewg_pkg.
module prewg_front import prewg_pkg::*; #(
  parameter int MAX_WIDTH   = 2048,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic                    cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  input  logic                    in_valid,
  input  logic                    opcode,
  input  logic [IN_BITS-1:0]      sample,
  output front_status_t           status,
  output logic                    push,
  output logic [SAMPLE_BITS+2:0]  push_gx,
  output logic [SAMPLE_BITS+2:0]  push_gy,
  output logic                    push_last,
  input  logic                    full
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int AW   = CW + 1;
  localparam int SB   = SAMPLE_BITS;
  localparam int SUMW = SB + 2;
  localparam int GW   = SB + 3;

  typedef enum logic [2:0] {S_IDLE, S_SMP, S_F1, S_F2, S_F3, S_J1, S_J2} state_t;

  state_t              state;
  logic [FW_BITS-1:0]  frame_width;
  logic [FH_BITS-1:0]  frame_height;
  logic [CW-1:0]       col_cnt;
  logic [ROW_BITS-1:0] row_cnt;
  logic [CW-1:0]       flush_cnt;
  logic                draining;
  logic [CW-1:0]       cur_c;
  logic [SB-1:0]       cur_s;
  logic                sel_up;
  logic                has_row;
  logic                need1;
  logic                need2;
  logic                job_last;

  logic [SB-1:0] upper_line  [0:MAX_WIDTH-1];
  logic [SB-1:0] middle_line [0:MAX_WIDTH-1];
  logic [SB-1:0] rd_up;
  logic [SB-1:0] rd_mid;
  logic [CW-1:0] rd_addr;

  logic [SB-1:0] win_top [0:2];
  logic [SB-1:0] win_mid [0:2];
  logic [SB-1:0] win_bot [0:2];

  logic [AW-1:0]       w_eff;
  logic [CW-1:0]       wl;
  logic [FH_BITS-1:0]  h_eff;
  logic [ROW_BITS-1:0] hl;
  logic [CW-1:0]       c_eff;
  logic                c_last;
  logic [CW-1:0]       f_eff;
  logic                f_last;
  logic [CW-1:0]       f_left;
  logic [CW-1:0]       cur_right;
  logic [SB-1:0]       col_top;
  logic [SB-1:0]       col_bot;
  logic                accept;
  logic                take_smp;
  logic                take_fl;
  logic                li;
  logic [1:0]          ci;
  logic [SUMW-1:0]     sum_l;
  logic [SUMW-1:0]     sum_r;
  logic [SUMW-1:0]     sum_up;
  logic [SUMW-1:0]     sum_dn;
  logic                job_ready;

  // effective frame size
  always_comb begin
    if (frame_width == '0) w_eff = AW'(1);
    else if (int'(frame_width) > MAX_WIDTH) w_eff = AW'(MAX_WIDTH);
    else w_eff = AW'(frame_width);
    if (frame_height == '0) h_eff = FH_BITS'(1);
    else if (int'(frame_height) > MAX_HEIGHT) h_eff = FH_BITS'(MAX_HEIGHT);
    else h_eff = frame_height;
  end

  assign wl = CW'(w_eff - AW'(1));
  assign hl = ROW_BITS'(h_eff - FH_BITS'(1));

  assign c_eff     = (col_cnt > wl) ? wl : col_cnt;
  assign c_last    = (c_eff == wl);
  assign f_eff     = (flush_cnt > wl) ? wl : flush_cnt;
  assign f_last    = (f_eff == wl);
  assign f_left    = (f_eff == '0) ? '0 : f_eff - CW'(1);
  assign cur_right = (cur_c == wl) ? cur_c : cur_c + CW'(1);

  assign accept   = in_valid && (state == S_IDLE);
  assign take_smp = accept && (opcode == OP_SAMPLE) && !draining;
  assign take_fl  = accept && (opcode == OP_FLUSH) && draining;

  assign status.busy     = (state != S_IDLE);
  assign status.draining = draining;

  always_comb begin
    case (state)
      S_IDLE:  rd_addr = (opcode == OP_FLUSH) ? f_left : c_eff;
      S_F1:    rd_addr = cur_c;
      S_F2:    rd_addr = cur_right;
      default: rd_addr = cur_c;
    endcase
  end

  // column entering the window from the line-store read
  assign col_top = sel_up ? rd_up : rd_mid;
  assign col_bot = (state == S_SMP) ? cur_s : rd_mid;

  // second job of a last column uses (w1, w2, w2)
  assign li = (state == S_J2);
  assign ci = (state == S_J2) ? 2'd2 : 2'd1;

  assign sum_l  = SUMW'(win_top[li]) + SUMW'(win_mid[li]) + SUMW'(win_bot[li]);
  assign sum_r  = SUMW'(win_top[2]) + SUMW'(win_mid[2]) + SUMW'(win_bot[2]);
  assign sum_up = SUMW'(win_top[li]) + SUMW'(win_top[ci]) + SUMW'(win_top[2]);
  assign sum_dn = SUMW'(win_bot[li]) + SUMW'(win_bot[ci]) + SUMW'(win_bot[2]);

  assign push_gx   = GW'(sum_r) - GW'(sum_l);
  assign push_gy   = GW'(sum_dn) - GW'(sum_up);
  assign push_last = (state == S_J1) && job_last;
  assign job_ready = (state == S_J1) || (state == S_J2);
  assign push      = job_ready && !full;

  always_ff @(posedge clk) begin
    rd_up  <= upper_line[rd_addr];
    rd_mid <= middle_line[rd_addr];
    if (state == S_SMP) begin
      upper_line[cur_c]  <= rd_mid;
      middle_line[cur_c] <= cur_s;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_SMP && has_row && cur_c == '0)) begin
      for (int i = 0; i < 3; i++) begin
        win_top[i] <= col_top;
        win_mid[i] <= rd_mid;
        win_bot[i] <= col_bot;
      end
    end else if ((state == S_SMP && has_row) || state == S_F1 || state == S_F2 ||
                 state == S_F3) begin
      win_top[0] <= win_top[1];
      win_mid[0] <= win_mid[1];
      win_bot[0] <= win_bot[1];
      win_top[1] <= win_top[2];
      win_mid[1] <= win_mid[2];
      win_bot[1] <= win_bot[2];
      win_top[2] <= col_top;
      win_mid[2] <= rd_mid;
      win_bot[2] <= col_bot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      frame_width  <= FW_RESET;
      frame_height <= FH_RESET;
      col_cnt      <= '0;
      row_cnt      <= '0;
      flush_cnt    <= '0;
      draining     <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_FRAME_WIDTH) frame_width <= cfg_data[FW_BITS-1:0];
        else frame_height <= cfg_data;
        col_cnt   <= '0;
        row_cnt   <= '0;
        flush_cnt <= '0;
        draining  <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take_smp) begin
            state    <= S_SMP;
            cur_c    <= c_eff;
            cur_s    <= SB'({{SB{1'b0}}, sample});
            sel_up   <= (row_cnt >= ROW_BITS'(2));
            has_row  <= (row_cnt != '0);
            need1    <= (row_cnt != '0) && (c_eff != '0);
            need2    <= (row_cnt != '0) && c_last;
            job_last <= 1'b0;
            if (c_last) begin
              col_cnt <= '0;
              if (row_cnt >= hl) begin
                row_cnt   <= hl;
                flush_cnt <= '0;
                draining  <= 1'b1;
              end else begin
                row_cnt <= row_cnt + ROW_BITS'(1);
              end
            end else begin
              col_cnt <= c_eff + CW'(1);
            end
          end else if (take_fl) begin
            state    <= S_F1;
            cur_c    <= f_eff;
            sel_up   <= (row_cnt != '0);
            has_row  <= 1'b0;
            need1    <= 1'b1;
            need2    <= 1'b0;
            job_last <= f_last;
            if (f_last) begin
              col_cnt   <= '0;
              row_cnt   <= '0;
              flush_cnt <= '0;
              draining  <= 1'b0;
            end else begin
              flush_cnt <= f_eff + CW'(1);
            end
          end
        end
        S_SMP: begin
          if (need1) state <= S_J1;
          else if (need2) state <= S_J2;
          else state <= S_IDLE;
        end
        S_F1: state <= S_F2;
        S_F2: state <= S_F3;
        S_F3: state <= S_J1;
        S_J1: begin
          if (!full) state <= need2 ? S_J2 : S_IDLE;
        end
        S_J2: begin
          if (!full) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/prewg_back.sv @@
// Back end: squares gx/gy, takes an integer square root two radicand bits
// per cycle, and holds the result in the output register. Uses prewg_pkg.
module prewg_back import prewg_pkg::*; #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  logic [SAMPLE_BITS+2:0] q_gx,
  input  logic [SAMPLE_BITS+2:0] q_gy,
  input  logic                   q_last,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [MAG_BITS-1:0]    magnitude,
  output logic                   frame_last
);

  localparam int GW  = SAMPLE_BITS + 3;
  localparam int RW  = SAMPLE_BITS + 3;
  localparam int RDW = 2 * RW;
  localparam int NW  = $clog2(RW + 1);

  typedef enum logic [1:0] {B_IDLE, B_SQ, B_ROOT, B_DONE} state_t;

  state_t                  state;
  logic signed [GW-1:0]    gx;
  logic signed [GW-1:0]    gy;
  logic                    last;
  logic [RDW-1:0]          rad;
  logic [RW+1:0]           rem;
  logic [RW-1:0]           root;
  logic [NW-1:0]           steps;
  logic signed [2*GW-1:0]  sqx;
  logic signed [2*GW-1:0]  sqy;
  logic [RW+1:0]           rem_sh;
  logic [RW+1:0]           trial;
  logic                    fits;
  logic [MAG_BITS+RW-1:0]  root_ext;

  assign sqx    = gx * gx;
  assign sqy    = gy * gy;
  assign rem_sh = {rem[RW-1:0], rad[RDW-1:RDW-2]};
  assign trial  = {root, 2'b01};
  assign fits   = (rem_sh >= trial);
  assign root_ext = {{MAG_BITS{1'b0}}, root};
  assign q_pop  = (state == B_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            gx    <= q_gx;
            gy    <= q_gy;
            last  <= q_last;
            state <= B_SQ;
          end
        end
        B_SQ: begin
          rad   <= RDW'(sqx + sqy);
          rem   <= '0;
          root  <= '0;
          steps <= '0;
          state <= B_ROOT;
        end
        B_ROOT: begin
          rad   <= {rad[RDW-3:0], 2'b00};
          rem   <= fits ? rem_sh - trial : rem_sh;
          root  <= {root[RW-2:0], fits};
          steps <= steps + NW'(1);
          if (steps == NW'(RW - 1)) state <= B_DONE;
        end
        B_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            magnitude  <= root_ext[MAG_BITS-1:0];
            frame_last <= last;
            state      <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

@@ bench/tb.sv @@
// Self-checking bench for prewitt_gradient_magnitude: directed table, then random frames.
// Depends on prewg_pkg and the block's RTL; carries its own bit-exact predictor.
module tb import prewg_pkg::*; ();

  localparam int LINE_DEPTH  = 2048;
  localparam int SETTLE      = 60;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int ITEM_GOAL   = 1650;
  localparam int PART_FRAME  = 300;      // samples sent of an oversized frame

  typedef struct packed {
    logic [IN_BITS-1:0] t;
    logic [IN_BITS-1:0] m;
    logic [IN_BITS-1:0] b;
  } column_t;

  typedef struct packed {
    logic [MAG_BITS-1:0] mag;
    logic                last;
  } grad_t;

  typedef enum int {ROW_CFG, ROW_ITEM, ROW_TYPED} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic               op;      // opcode, or register index on a config row
    logic [12:0]        val;     // sample or register value
    int                 n;       // typed result count
    grad_t              r0;
    grad_t              r1;
  } row_t;

  logic                clk;
  logic                rst;
  logic                cfg_write;
  logic                cfg_index;
  logic [CFG_BITS-1:0] cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic                opcode;
  logic [IN_BITS-1:0]  sample;
  logic                out_valid;
  logic                out_stall;
  logic [MAG_BITS-1:0] magnitude;
  logic                frame_last;

  prewitt_gradient_magnitude dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .magnitude(magnitude), .frame_last(frame_last)
  );

  // predictor state
  logic [IN_BITS-1:0] up_line  [LINE_DEPTH];
  logic [IN_BITS-1:0] mid_line [LINE_DEPTH];
  column_t            win [3];
  int                 col_n, row_n, flush_n;
  bit                 drain;
  logic [FW_BITS-1:0] width_reg;
  logic [FH_BITS-1:0] height_reg;

  grad_t pending_q[$];     // expected magnitudes, oldest first
  int    errors = 0;
  int    cycles = 0;
  int    items_sent;
  bit    calm;             // no idling on either side
  bit    hold_req = 1'b0;  // receiver takes one long hold-off

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int frame_w();
    if (width_reg == 0) return 1;
    if (width_reg > LINE_DEPTH) return LINE_DEPTH;
    return width_reg;
  endfunction

  function automatic int frame_h();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return height_reg;
  endfunction

  function automatic void restart_frame();
    col_n = 0;
    row_n = 0;
    flush_n = 0;
    drain = 0;
  endfunction

  function automatic logic [MAG_BITS-1:0] prewitt_mag(column_t l, column_t c, column_t r);
    longint gx, gy;
    longint unsigned v, res, bitv;
    gx = (longint'(r.t) + r.m + r.b) - (longint'(l.t) + l.m + l.b);
    gy = (longint'(l.b) + c.b + r.b) - (longint'(l.t) + c.t + r.t);
    v = gx * gx + gy * gy;
    res = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[MAG_BITS-1:0];
  endfunction

  function automatic column_t stored_col(int i);
    column_t k;
    k.m = mid_line[i];
    k.b = mid_line[i];
    k.t = (row_n >= 1) ? up_line[i] : mid_line[i];
    return k;
  endfunction

  function automatic int clamp_idx(int i, int w);
    if (i < 0) return 0;
    if (i >= w) return w - 1;
    return i;
  endfunction

  // One accepted item: returns how many results it causes.
  function automatic int predict_grad(logic op, logic [IN_BITS-1:0] s,
                                      output grad_t g0, output grad_t g1);
    int w, h, n, c, r, f;
    bit last_col;
    column_t nc;
    grad_t g [2];
    w = frame_w();
    h = frame_h();
    n = 0;
    g[0] = '0;
    g[1] = '0;
    g0 = '0;
    g1 = '0;
    if (op == OP_FLUSH) begin
      if (!drain) return 0;
      f = flush_n;
      if (f >= w) f = w - 1;
      g0.mag = prewitt_mag(stored_col(clamp_idx(f - 1, w)), stored_col(f),
                           stored_col(clamp_idx(f + 1, w)));
      g0.last = (f == w - 1);
      if (f == w - 1) restart_frame();
      else flush_n = f + 1;
      return 1;
    end
    if (drain) return 0;
    c = col_n;
    r = row_n;
    if (c >= w) c = w - 1;
    last_col = (c == w - 1);
    nc.m = mid_line[c];
    nc.t = (r >= 2) ? up_line[c] : mid_line[c];
    nc.b = s;
    if (r >= 1) begin
      if (c == 0) begin
        win[0] = nc;
        win[1] = nc;
        win[2] = nc;
      end else begin
        win[0] = win[1];
        win[1] = win[2];
        win[2] = nc;
        g[n].mag = prewitt_mag(win[0], win[1], win[2]);
        n++;
      end
      if (last_col) begin
        g[n].mag = prewitt_mag(win[1], win[2], win[2]);
        n++;
      end
    end
    up_line[c] = mid_line[c];
    mid_line[c] = s;
    if (last_col) begin
      col_n = 0;
      if (r >= h - 1) begin
        row_n = h - 1;
        flush_n = 0;
        drain = 1;
      end else begin
        row_n = r + 1;
      end
    end else begin
      col_n = c + 1;
    end
    g0 = g[0];
    g1 = g[1];
    return n;
  endfunction

  // Drain everything in flight, then let the block settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [12:0] val);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_FRAME_WIDTH) width_reg = val[FW_BITS-1:0];
    else height_reg = val[FH_BITS-1:0];
    restart_frame();
  endtask

  // Offer one item; at acceptance predict it. Typed rows push their own values.
  task automatic send_item(logic op, logic [IN_BITS-1:0] s, row_t row, bit typed);
    int gap, n;
    grad_t g0, g1;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    sample   <= s;
    do @(posedge clk); while (in_stall);
    items_sent++;
    n = predict_grad(op, s, g0, g1);
    if (typed) begin
      n  = row.n;
      g0 = row.r0;
      g1 = row.r1;
    end
    if (n >= 1) pending_q.push_back(g0);
    if (n >= 2) pending_q.push_back(g1);
  endtask

  // Receiver: random stall per item, one long hold-off on request.
  initial begin : sink
    int k;
    grad_t want;
    bit held;
    held = 1'b0;
    out_stall = 1'b1;
    @(negedge rst);
    @(posedge clk);
    forever begin
      k = calm ? 0 : $urandom_range(0, 6);
      if (hold_req && !held) begin
        k = 400;
        held = 1'b1;
      end
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual mag=%0d last=%0b",
                 $time, magnitude, frame_last);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (magnitude !== want.mag) begin
          $display("%0t: magnitude expected %0d actual %0d", $time, want.mag, magnitude);
          errors++;
        end
        if (frame_last !== want.last) begin
          $display("%0t: frame_last expected %0b actual %0b", $time, want.last,
                   frame_last);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    row_t tbl[$];
    row_t rw;
    row_t none;
    int frame_no, w, h, mode, cut, count;
    logic [IN_BITS-1:0] s;

    items_sent = 0;
    calm = 0;
    cfg_write = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data = '0;
    in_valid = 1'b0;
    opcode = OP_SAMPLE;
    sample = '0;
    width_reg = FW_RESET;
    height_reg = FH_RESET;
    restart_frame();
    none = '{ROW_ITEM, OP_SAMPLE, 13'd0, 0, '0, '0};

    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // 2x2 frame: dark top row, full-scale bottom row -> pure vertical gradient
    tbl.push_back('{ROW_CFG,   REG_FRAME_WIDTH,  13'd2, 0, '0, '0});
    tbl.push_back('{ROW_CFG,   REG_FRAME_HEIGHT, 13'd2, 0, '0, '0});
    tbl.push_back('{ROW_TYPED, OP_FLUSH,  13'd0,    0, '0, '0});   // flush outside drain
    tbl.push_back('{ROW_TYPED, OP_SAMPLE, 13'd0,    0, '0, '0});
    tbl.push_back('{ROW_TYPED, OP_SAMPLE, 13'd0,    0, '0, '0});
    tbl.push_back('{ROW_TYPED, OP_SAMPLE, 13'd4095, 0, '0, '0});
    tbl.push_back('{ROW_TYPED, OP_SAMPLE, 13'd4095, 2, '{15'd12285, 1'b0},
                    '{15'd12285, 1'b0}});
    tbl.push_back('{ROW_TYPED, OP_SAMPLE, 13'd7,    0, '0, '0});   // sample during drain
    tbl.push_back('{ROW_TYPED, OP_FLUSH,  13'd0,    1, '{15'd12285, 1'b0}, '0});
    tbl.push_back('{ROW_TYPED, OP_FLUSH,  13'd0,    1, '{15'd12285, 1'b1}, '0});
    tbl.push_back('{ROW_TYPED, OP_FLUSH,  13'd0,    0, '0, '0});
    // zero registers clamp to a 1x1 frame: flat window, magnitude 0
    tbl.push_back('{ROW_CFG,   REG_FRAME_WIDTH,  13'd0, 0, '0, '0});
    tbl.push_back('{ROW_CFG,   REG_FRAME_HEIGHT, 13'd0, 0, '0, '0});
    tbl.push_back('{ROW_TYPED, OP_SAMPLE, 13'd4095, 0, '0, '0});
    tbl.push_back('{ROW_TYPED, OP_FLUSH,  13'd0,    1, '{15'd0, 1'b1}, '0});
    // 3x2 checker, predicted
    tbl.push_back('{ROW_CFG,   REG_FRAME_WIDTH,  13'd3, 0, '0, '0});
    tbl.push_back('{ROW_CFG,   REG_FRAME_HEIGHT, 13'd2, 0, '0, '0});
    tbl.push_back('{ROW_ITEM,  OP_SAMPLE, 13'd0,    0, '0, '0});
    tbl.push_back('{ROW_ITEM,  OP_SAMPLE, 13'd4095, 0, '0, '0});
    tbl.push_back('{ROW_ITEM,  OP_SAMPLE, 13'd0,    0, '0, '0});
    tbl.push_back('{ROW_ITEM,  OP_SAMPLE, 13'd4095, 0, '0, '0});
    tbl.push_back('{ROW_ITEM,  OP_SAMPLE, 13'd0,    0, '0, '0});
    tbl.push_back('{ROW_ITEM,  OP_SAMPLE, 13'd4095, 0, '0, '0});
    tbl.push_back('{ROW_ITEM,  OP_FLUSH,  13'd0,    0, '0, '0});
    tbl.push_back('{ROW_ITEM,  OP_FLUSH,  13'd0,    0, '0, '0});
    tbl.push_back('{ROW_ITEM,  OP_FLUSH,  13'd0,    0, '0, '0});

    foreach (tbl[i]) begin
      rw = tbl[i];
      if (rw.kind == ROW_CFG) write_reg(rw.op, rw.val);
      else send_item(rw.op, rw.val[IN_BITS-1:0], rw, rw.kind == ROW_TYPED);
    end

    // random frames; a few extreme shapes at fixed positions
    frame_no = 0;
    while (items_sent < ITEM_GOAL || frame_no < 8) begin
      calm = ($urandom_range(0, 7) == 0);
      case (frame_no)
        3: begin w = 4095; h = 1; end          // clamps to full line width
        6: begin w = 1; h = 8191; end          // clamps to full height
        default: begin
          w = $urandom_range(1, 12);
          h = $urandom_range(1, 8);
        end
      endcase
      if ($urandom_range(0, 1)) begin
        write_reg(REG_FRAME_WIDTH, 13'(w));
        write_reg(REG_FRAME_HEIGHT, 13'(h));
      end else begin
        write_reg(REG_FRAME_HEIGHT, 13'(h));
        write_reg(REG_FRAME_WIDTH, 13'(w));
      end
      if (w > LINE_DEPTH) w = LINE_DEPTH;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      mode = $urandom_range(0, 3);
      // occasionally abandon a frame midway; the next write restarts it
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, w * h - 1) : w * h;
      // oversized frames are only started, to keep the item count in line
      if (frame_no == 3 || frame_no == 6) cut = PART_FRAME;
      count = 0;
      for (int p = 0; p < cut; p++) begin
        if (frame_no == 6 && p == 100) hold_req = 1;
        if ($urandom_range(0, 11) == 0) send_item(OP_FLUSH, IN_BITS'($urandom), none, 0);
        case (mode)
          1: s = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
          2: s = IN_BITS'(2000 + $urandom_range(0, 63));
          default: s = IN_BITS'($urandom);
        endcase
        send_item(OP_SAMPLE, s, none, 0);
      end
      if (cut == w * h) begin
        for (int p = 0; p < w; p++) begin
          if ($urandom_range(0, 9) == 0) send_item(OP_SAMPLE, IN_BITS'($urandom), none, 0);
          send_item(OP_FLUSH, IN_BITS'($urandom), none, 0);
        end
      end
      frame_no++;
    end

    calm = 0;
    wait_idle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
